// File: src/pmsc_pkg.sv
`timescale 1ns / 1ps

package pmsc_pkg;

    localparam int ALPHABET_SIZE   = 10;
    localparam int MAX_WORD_LENGTH = 65536;

    localparam int LETTER_W   = 4;
    localparam int TOTAL_W    = 32;
    localparam int MASK_W     = ALPHABET_SIZE;
    localparam int HIST_DEPTH = 1 << MASK_W;
    localparam int HIST_W     = $clog2(2 * MAX_WORD_LENGTH);
    localparam logic [HIST_W-1:0] HIST_CAP = HIST_W'(2 * MAX_WORD_LENGTH - 1);

    localparam int STEP_W = $clog2(ALPHABET_SIZE + 2);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(ALPHABET_SIZE + 1);

    typedef struct packed {
        logic [LETTER_W-1:0] letter;
        logic                last;
    } item_t;

    typedef struct packed {
        logic [TOTAL_W-1:0] total;
        logic               final_res;
    } res_t;

    typedef struct packed {
        logic              load_item;
        logic              clr_step;
        logic              rd_issue;
        logic [STEP_W-1:0] rd_idx;
        logic              acc_en;
        logic              cap_m;
        logic              wr_inc;
        logic              out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
        logic clr_last;
        logic item_last;
    } dp_status_t;

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_RUN   = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    function automatic logic [MASK_W-1:0] letter_flip(input logic [LETTER_W-1:0] letter);
        logic [MASK_W-1:0] f;
        for (int i = 0; i < MASK_W; i++)
        begin
            f[i] = (letter == LETTER_W'(i));
        end
        return f;
    endfunction

    function automatic logic [MASK_W-1:0] step_flip(input logic [STEP_W-1:0] idx);
        logic [MASK_W-1:0] f;
        for (int i = 0; i < MASK_W; i++)
        begin
            f[i] = (idx == STEP_W'(i + 1));
        end
        return f;
    endfunction

endpackage

// File: src/parity_mask_substring_counter_unit.sv
`timescale 1ns / 1ps

// Counts substrings with at most one odd-count letter, one letter per transfer.
// Each letter runs through these steps before the next transfer can be taken:
// one to take the letter, twelve on the single-port 1024-entry histogram memory
// (eleven reads, one read-modify-write), one to load the result register.
// A result waits in its register while the next letter is taken. After reset
// and after every letter marked last, a clearing pass rewrites the whole
// histogram, one entry per cycle, and no letter is taken until it ends.

module parity_mask_substring_counter_unit (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             letter_valid,
    output logic             letter_stall,
    input  pmsc_pkg::item_t  letter_item,
    output logic             result_valid,
    input  logic             result_stall,
    output pmsc_pkg::res_t   result
);

    pmsc_pkg::dp_cmd_t    cmd;
    pmsc_pkg::dp_status_t sts;

    pmsc_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .letter_valid (letter_valid),
        .letter_stall (letter_stall),
        .sts          (sts),
        .cmd          (cmd)
    );

    pmsc_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .letter_item  (letter_item),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .result       (result),
        .cmd          (cmd),
        .sts          (sts)
    );

endmodule

// File: src/pmsc_ctrl.sv
`timescale 1ns / 1ps

module pmsc_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  letter_valid,
    output logic                  letter_stall,
    input  pmsc_pkg::dp_status_t  sts,
    output pmsc_pkg::dp_cmd_t     cmd
);

    pmsc_pkg::state_t                state_reg;
    pmsc_pkg::state_t                state_next;
    logic [pmsc_pkg::STEP_W-1:0]     cnt_reg;
    logic [pmsc_pkg::STEP_W-1:0]     cnt_next;

    assign letter_stall = (state_reg != pmsc_pkg::ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            pmsc_pkg::ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = pmsc_pkg::ST_IDLE;
                end
            end
            pmsc_pkg::ST_IDLE:
            begin
                cmd.load_item = letter_valid;
                if (letter_valid)
                begin
                    state_next = pmsc_pkg::ST_RUN;
                    cnt_next   = '0;
                end
            end
            pmsc_pkg::ST_RUN:
            begin
                cmd.rd_issue = (cnt_reg != pmsc_pkg::STEP_LAST);
                cmd.rd_idx   = cnt_reg;
                cmd.acc_en   = (cnt_reg != '0);
                cmd.cap_m    = (cnt_reg == pmsc_pkg::STEP_W'(1));
                cmd.wr_inc   = (cnt_reg == pmsc_pkg::STEP_LAST);
                cnt_next     = cnt_reg + pmsc_pkg::STEP_W'(1);
                if (cnt_reg == pmsc_pkg::STEP_LAST)
                begin
                    state_next = pmsc_pkg::ST_DONE;
                end
            end
            pmsc_pkg::ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = sts.item_last ? pmsc_pkg::ST_CLEAR : pmsc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pmsc_pkg::ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pmsc_pkg::ST_CLEAR;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    a_run_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pmsc_pkg::ST_RUN) |-> (cnt_reg <= pmsc_pkg::STEP_LAST))
        else $error("step count out of range");

    a_accept_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
        (letter_valid && !letter_stall) |=> (state_reg == pmsc_pkg::ST_RUN && cnt_reg == '0))
        else $error("transfer did not start a run");

    a_run_ends_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pmsc_pkg::ST_RUN && cnt_reg == pmsc_pkg::STEP_LAST)
        |=> (state_reg == pmsc_pkg::ST_DONE))
        else $error("run did not finish in done");

endmodule

// File: src/pmsc_dp.sv
`timescale 1ns / 1ps

module pmsc_dp (
    input  logic                  clk,
    input  logic                  rst_n,
    input  pmsc_pkg::item_t       letter_item,
    input  logic                  result_stall,
    output logic                  result_valid,
    output pmsc_pkg::res_t        result,
    input  pmsc_pkg::dp_cmd_t     cmd,
    output pmsc_pkg::dp_status_t  sts
);

    logic [pmsc_pkg::HIST_W-1:0]  hist_mem [pmsc_pkg::HIST_DEPTH];
    logic [pmsc_pkg::HIST_W-1:0]  rd_data_reg;
    logic [pmsc_pkg::HIST_W-1:0]  hist_m_reg;
    logic [pmsc_pkg::MASK_W-1:0]  mask_reg;
    logic [pmsc_pkg::MASK_W-1:0]  clr_addr_reg;
    logic [pmsc_pkg::TOTAL_W-1:0] acc_reg;
    logic [pmsc_pkg::TOTAL_W-1:0] acc_next;
    logic [pmsc_pkg::TOTAL_W:0]   acc_sum;
    logic                         last_reg;
    logic                         res_valid_reg;
    pmsc_pkg::res_t               res_reg;

    logic                         mem_we;
    logic [pmsc_pkg::MASK_W-1:0]  mem_addr;
    logic [pmsc_pkg::HIST_W-1:0]  mem_wdata;

    assign sts.out_free  = !res_valid_reg || !result_stall;
    assign sts.clr_last  = (clr_addr_reg == pmsc_pkg::MASK_W'(pmsc_pkg::HIST_DEPTH - 1));
    assign sts.item_last = last_reg;

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    always_comb
    begin
        mem_we    = cmd.clr_step || cmd.wr_inc;
        mem_addr  = mask_reg ^ pmsc_pkg::step_flip(cmd.rd_idx);
        mem_wdata = (hist_m_reg != pmsc_pkg::HIST_CAP)
                    ? hist_m_reg + pmsc_pkg::HIST_W'(1) : hist_m_reg;
        if (cmd.clr_step)
        begin
            mem_addr  = clr_addr_reg;
            mem_wdata = (clr_addr_reg == '0) ? pmsc_pkg::HIST_W'(1) : '0;
        end
        else if (cmd.wr_inc)
        begin
            mem_addr = mask_reg;
        end
    end

    // saturating add of one histogram count
    assign acc_sum  = {1'b0, acc_reg} + (pmsc_pkg::TOTAL_W + 1)'(rd_data_reg);
    assign acc_next = acc_sum[pmsc_pkg::TOTAL_W] ? '1 : acc_sum[pmsc_pkg::TOTAL_W-1:0];

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            hist_mem[mem_addr] <= mem_wdata;
        end
        else if (cmd.rd_issue)
        begin
            rd_data_reg <= hist_mem[mem_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cap_m)
        begin
            hist_m_reg <= rd_data_reg;
        end
        if (cmd.out_load)
        begin
            res_reg.total     <= acc_reg;
            res_reg.final_res <= last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= '0;
            acc_reg       <= '0;
            last_reg      <= 1'b0;
            clr_addr_reg  <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_step)
            begin
                clr_addr_reg <= clr_addr_reg + pmsc_pkg::MASK_W'(1);
            end
            if (cmd.load_item)
            begin
                mask_reg <= mask_reg ^ pmsc_pkg::letter_flip(letter_item.letter);
                last_reg <= letter_item.last;
            end
            if (cmd.acc_en)
            begin
                acc_reg <= acc_next;
            end
            if (cmd.out_load)
            begin
                res_valid_reg <= 1'b1;
                // drop word state after the final letter
                if (last_reg)
                begin
                    mask_reg <= '0;
                    acc_reg  <= '0;
                end
            end
            else if (!result_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    a_port_single_use: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && cmd.rd_issue))
        else $error("memory write and read in one cycle");

    a_out_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!res_valid_reg || !result_stall))
        else $error("result overwritten before transfer");

    a_clear_word_state: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.clr_step && sts.clr_last) |=> (mask_reg == '0 && acc_reg == '0))
        else $error("word state not cleared after clearing pass");

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int N_DIRECTED   = 21;
    localparam int RANDOM_ITEMS = 530;
    localparam int QUIET_TAIL   = 80;
    localparam int PAUSE_AT     = 250;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 2000000;

    typedef struct {
        logic [pmsc_pkg::LETTER_W-1:0] letter;
        logic                          last;
        bit                            typed;
        logic [pmsc_pkg::TOTAL_W-1:0]  total;
    } word_row_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              letter_valid;
    logic              letter_stall;
    pmsc_pkg::item_t   letter_item;
    logic              result_valid;
    logic              result_stall;
    pmsc_pkg::res_t    result;

    logic [pmsc_pkg::MASK_W-1:0]  parity;
    logic [pmsc_pkg::HIST_W-1:0]  mask_count [pmsc_pkg::HIST_DEPTH];
    logic [pmsc_pkg::TOTAL_W-1:0] substr_total;

    pmsc_pkg::res_t pending_totals [$];
    int unsigned    errors;
    int unsigned    cycle_count;
    int unsigned    stall_left;
    bit             idle_on;

    word_row_t directed [N_DIRECTED] = '{
        '{4'd0,  1'b1, 1'b1, 32'd1},
        '{4'd9,  1'b1, 1'b1, 32'd1},
        '{4'd15, 1'b1, 1'b1, 32'd1},
        '{4'd0,  1'b0, 1'b1, 32'd1},
        '{4'd0,  1'b1, 1'b1, 32'd3},
        '{4'd0,  1'b0, 1'b0, 32'd0},
        '{4'd1,  1'b0, 1'b0, 32'd0},
        '{4'd2,  1'b0, 1'b0, 32'd0},
        '{4'd3,  1'b0, 1'b0, 32'd0},
        '{4'd4,  1'b0, 1'b0, 32'd0},
        '{4'd5,  1'b0, 1'b0, 32'd0},
        '{4'd6,  1'b0, 1'b0, 32'd0},
        '{4'd7,  1'b0, 1'b0, 32'd0},
        '{4'd8,  1'b0, 1'b0, 32'd0},
        '{4'd9,  1'b0, 1'b0, 32'd0},
        '{4'd10, 1'b0, 1'b0, 32'd0},
        '{4'd11, 1'b0, 1'b0, 32'd0},
        '{4'd12, 1'b0, 1'b0, 32'd0},
        '{4'd13, 1'b0, 1'b0, 32'd0},
        '{4'd14, 1'b0, 1'b0, 32'd0},
        '{4'd15, 1'b1, 1'b0, 32'd0}
    };

    parity_mask_substring_counter_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .letter_valid (letter_valid),
        .letter_stall (letter_stall),
        .letter_item  (letter_item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic void clear_word();
        parity       = '0;
        substr_total = '0;
        for (int i = 0; i < pmsc_pkg::HIST_DEPTH; i++)
        begin
            mask_count[i] = '0;
        end
        mask_count[0] = pmsc_pkg::HIST_W'(1);
    endfunction

    function automatic pmsc_pkg::res_t count_letter(input pmsc_pkg::item_t it);
        logic [pmsc_pkg::MASK_W-1:0] m;
        longint unsigned             acc;
        pmsc_pkg::res_t              r;
        m = parity;
        if (it.letter < pmsc_pkg::ALPHABET_SIZE)
        begin
            m = m ^ (pmsc_pkg::MASK_W'(1) << it.letter);
        end
        parity = m;
        acc = longint'(substr_total) + longint'(mask_count[m]);
        for (int b = 0; b < pmsc_pkg::MASK_W; b++)
        begin
            acc += longint'(mask_count[m ^ (pmsc_pkg::MASK_W'(1) << b)]);
        end
        if (acc > 64'hFFFF_FFFF)
        begin
            acc = 64'hFFFF_FFFF;
        end
        substr_total = acc[pmsc_pkg::TOTAL_W-1:0];
        if (mask_count[m] < pmsc_pkg::HIST_CAP)
        begin
            mask_count[m] = mask_count[m] + 1'b1;
        end
        r.total     = substr_total;
        r.final_res = it.last;
        if (it.last)
        begin
            clear_word();
        end
        return r;
    endfunction

    // Hold the letter until its transfer, then record the expected total.
    task automatic send_letter(input logic [pmsc_pkg::LETTER_W-1:0] l,
                               input logic lst,
                               input bit typed,
                               input logic [pmsc_pkg::TOTAL_W-1:0] typed_total);
        pmsc_pkg::item_t it;
        pmsc_pkg::res_t  r;
        it.letter = l;
        it.last   = lst;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            letter_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        letter_valid <= 1'b1;
        letter_item  <= it;
        do
            @(posedge clk);
        while (letter_stall);
        r = count_letter(it);
        if (typed)
        begin
            r.total = typed_total;
        end
        pending_totals.push_back(r);
    endtask

    function automatic logic [pmsc_pkg::LETTER_W-1:0] pick_letter(
        input bit                            narrow,
        input logic [pmsc_pkg::LETTER_W-1:0] base);
        if ($urandom_range(0, 11) == 0)
        begin
            return pmsc_pkg::LETTER_W'($urandom_range(pmsc_pkg::ALPHABET_SIZE, 15));
        end
        if (narrow)
        begin
            return base + pmsc_pkg::LETTER_W'($urandom_range(0, 1));
        end
        return pmsc_pkg::LETTER_W'($urandom_range(0, pmsc_pkg::ALPHABET_SIZE - 1));
    endfunction

    initial
    begin
        int                            sent;
        int                            word_len;
        bit                            narrow;
        bit                            paused;
        logic [pmsc_pkg::LETTER_W-1:0] base;
        rst_n        <= 1'b0;
        letter_valid <= 1'b0;
        letter_item  <= '0;
        idle_on      = 1'b1;
        sent         = 0;
        paused       = 1'b0;
        clear_word();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++)
        begin
            send_letter(directed[i].letter, directed[i].last,
                        directed[i].typed, directed[i].total);
        end

        while (sent < RANDOM_ITEMS)
        begin
            if (!paused && sent >= PAUSE_AT)
            begin
                letter_valid <= 1'b0;
                while (pending_totals.size() != 0) @(posedge clk);
                @(posedge clk);
                paused = 1'b1;
            end
            idle_on  = (sent < RANDOM_ITEMS - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
            word_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                   : $urandom_range(1, 10);
            narrow   = ($urandom_range(0, 2) == 0);
            base     = pmsc_pkg::LETTER_W'($urandom_range(0, pmsc_pkg::ALPHABET_SIZE - 2));
            for (int i = 0; i < word_len; i++)
            begin
                send_letter(pick_letter(narrow, base), i == word_len - 1, 1'b0, '0);
                sent++;
            end
        end

        letter_valid <= 1'b0;
        while (pending_totals.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
        begin
            $display("parity_mask_substring_counter_unit test passed");
        end
        else
        begin
            $display("parity_mask_substring_counter_unit test failed");
        end
        $finish;
    end

    initial
    begin
        result_stall <= 1'b0;
        errors       = 0;
        stall_left   = 0;
        cycle_count  = 0;
    end

    always @(posedge clk)
    begin
        pmsc_pkg::res_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_totals.size() == 0)
            begin
                $error("result: unexpected transfer, total %0d", result.total);
                errors++;
            end
            else
            begin
                want = pending_totals.pop_front();
                if (result.total !== want.total)
                begin
                    $error("total: expected %0d, got %0d", want.total, result.total);
                    errors++;
                end
                if (result.final_res !== want.final_res)
                begin
                    $error("final_res: expected %0d, got %0d", want.final_res,
                           result.final_res);
                    errors++;
                end
            end
        end
        if (stall_left > 0)
        begin
            result_stall <= 1'b1;
            stall_left   = stall_left - 1;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            result_stall <= 1'b1;
            stall_left   = $urandom_range(0, 3);
        end
        else
        begin
            result_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("parity_mask_substring_counter_unit test failed");
            $finish;
        end
    end

endmodule

// File: parity_mask_substring_counter_unit.f
src/pmsc_pkg.sv
src/pmsc_ctrl.sv
src/pmsc_dp.sv
src/parity_mask_substring_counter_unit.sv
tb/sv/tb.sv
